[hw/rtl/vad_pkg.sv]
// ----------------------------------------------------------------------------
// vad_pkg
// Shared constants and tables for the vector angle pipeline.
// ----------------------------------------------------------------------------
package vad_pkg;

  // default configuration
  localparam int COORD_BITS_DEF      = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // queue between the classifier and the arithmetic pipeline
  localparam int QUEUE_DEPTH = 4;

  // normalized squared length lives in [2^60, 2^62)
  localparam int NORM_BITS  = 62;
  localparam int NORM_STEPS = 5;   // greedy shift steps of 16, 8, 4, 2, 1 pairs
  localparam int K_BITS     = 5;
  localparam int K_MAX      = 30;
  localparam int ROOT_BITS  = NORM_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 3;

  // cosine quotient
  localparam int COS_FRAC   = 15;
  localparam int Q_BITS     = COS_FRAC + 2;
  localparam int QC_BITS    = COS_FRAC + 1;
  localparam int SV_BITS    = 2 * QC_BITS;
  localparam int SROOT_BITS = QC_BITS;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int XY_BITS      = QC_BITS + 3;
  localparam int Z_BITS       = 26;
  localparam int ZC_BITS      = 24;
  localparam int Z_FRAC       = 16;
  localparam int Z_QUARTER    = 90 * 65536;
  localparam int Z_HALF       = 180 * 65536;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [21:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  // one digit of the square root recurrence
  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqr_t;

  function automatic sqr_t sqrt_step(logic [REM_BITS-1:0] rem,
                                     logic [ROOT_BITS-1:0] root,
                                     logic [1:0] pair);
    logic [REM_BITS-1:0] t;
    logic [REM_BITS-1:0] tr;
    sqr_t res;
    t  = {rem[REM_BITS-3:0], pair};
    tr = {1'b0, root, 2'b01};
    if (t >= tr) begin
      res.rem  = t - tr;
      res.root = {root[ROOT_BITS-2:0], 1'b1};
    end else begin
      res.rem  = t;
      res.root = {root[ROOT_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[hw/rtl/vad_queue.sv]
// ----------------------------------------------------------------------------
// vad_queue
// Small register queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module vad_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = vad_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop_ready,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/vad_front.sv]
// ----------------------------------------------------------------------------
// vad_front
// Input side: forms dot product and squared lengths, flags zero length.
// ----------------------------------------------------------------------------
module vad_front #(
  parameter int COORD_BITS = vad_pkg::COORD_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_first_x,
  input  logic signed [COORD_BITS-1:0]  in_first_y,
  input  logic signed [COORD_BITS-1:0]  in_first_z,
  input  logic signed [COORD_BITS-1:0]  in_second_x,
  input  logic signed [COORD_BITS-1:0]  in_second_y,
  input  logic signed [COORD_BITS-1:0]  in_second_z,
  input  logic                          q_full,
  output logic                          push_valid,
  output logic                          push_zl,
  output logic                          push_neg,
  output logic [2*COORD_BITS-1:0]       push_mag,
  output logic [2*COORD_BITS-1:0]       push_la,
  output logic [2*COORD_BITS-1:0]       push_lb
);
  localparam int MW = 2 * COORD_BITS;

  logic signed [MW-1:0]   pxx, pyy, pzz;
  logic signed [MW-1:0]   sax, say, saz, sbx, sby, sbz;
  logic signed [MW+1:0]   dot;

  // products
  assign pxx = in_first_x * in_second_x;
  assign pyy = in_first_y * in_second_y;
  assign pzz = in_first_z * in_second_z;
  assign sax = in_first_x * in_first_x;
  assign say = in_first_y * in_first_y;
  assign saz = in_first_z * in_first_z;
  assign sbx = in_second_x * in_second_x;
  assign sby = in_second_y * in_second_y;
  assign sbz = in_second_z * in_second_z;

  // sums, sign and magnitude
  assign dot      = (MW+2)'(pxx) + (MW+2)'(pyy) + (MW+2)'(pzz);
  assign push_neg = dot[MW+1];
  assign push_mag = push_neg ? MW'(-dot) : MW'(dot);
  assign push_la  = $unsigned(sax) + $unsigned(say) + $unsigned(saz);
  assign push_lb  = $unsigned(sbx) + $unsigned(sby) + $unsigned(sbz);
  assign push_zl  = (push_la == '0) || (push_lb == '0);

  // handshake toward the queue
  assign in_stall   = q_full;
  assign push_valid = in_valid && !q_full;

endmodule

[hw/rtl/vad_back.sv]
// ----------------------------------------------------------------------------
// vad_back
// Arithmetic pipeline: normalize, roots, cosine divide, sine root, cordic.
// ----------------------------------------------------------------------------
module vad_back #(
  parameter int COORD_BITS      = vad_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  output logic                           head_ready,
  input  logic                           head_zl,
  input  logic                           head_neg,
  input  logic [2*COORD_BITS-1:0]        head_mag,
  input  logic [2*COORD_BITS-1:0]        head_la,
  input  logic [2*COORD_BITS-1:0]        head_lb,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [8+ANGLE_FRAC_BITS-1:0]   out_angle_deg,
  output logic                           out_zero_length
);
  import vad_pkg::*;

  localparam int MW   = 2 * COORD_BITS;
  localparam int AW   = 8 + ANGLE_FRAC_BITS;
  localparam int SHW  = COS_FRAC + 2 * K_MAX;
  localparam int NW   = MW + SHW;
  localparam int HW   = NW - Q_BITS;
  localparam int DRW  = NORM_BITS + 1;

  // stage map
  localparam int S_FIX    = NORM_STEPS;
  localparam int S_ROOT0  = S_FIX + 1;
  localparam int S_DEN    = S_ROOT0 + ROOT_BITS;
  localparam int S_DINIT  = S_DEN + 1;
  localparam int S_DIV0   = S_DINIT + 1;
  localparam int S_QC     = S_DIV0 + Q_BITS;
  localparam int S_SQ     = S_QC + 1;
  localparam int S_SROOT0 = S_SQ + 1;
  localparam int S_CINIT  = S_SROOT0 + SROOT_BITS;
  localparam int S_CORD0  = S_CINIT + 1;
  localparam int S_ROUND  = S_CORD0 + CORDIC_STEPS;
  localparam int NS       = S_ROUND + 1;

  localparam logic [ZC_BITS:0] RND     = (ZC_BITS+1)'(1) << (Z_FRAC - 1 - ANGLE_FRAC_BITS);
  localparam logic [AW-1:0]    ANG_MAX = AW'(180) << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic                      zl;
    logic                      neg;
    logic [MW-1:0]             mag;
    logic [NORM_BITS-1:0]      ra;
    logic [NORM_BITS-1:0]      rb;
    logic [K_BITS-1:0]         ka;
    logic [K_BITS-1:0]         kb;
    logic [REM_BITS-1:0]       rema;
    logic [ROOT_BITS-1:0]      roota;
    logic [REM_BITS-1:0]       remb;
    logic [ROOT_BITS-1:0]      rootb;
    logic [NORM_BITS-1:0]      den;
    logic [NW-1:0]             num;
    logic [DRW-1:0]            drem;
    logic [Q_BITS-1:0]         q;
    logic                      sat;
    logic [QC_BITS-1:0]        qc;
    logic signed [XY_BITS-1:0] cx;
    logic signed [XY_BITS-1:0] cy;
    logic signed [Z_BITS-1:0]  cz;
    logic [AW-1:0]             ang;
  } stage_t;

  stage_t       head;
  stage_t       pipe_r [NS];
  logic [NS-1:0] vld_r;
  logic          adv;

  // whole pipeline moves unless the result register is held
  assign adv        = !(vld_r[NS-1] && out_stall);
  assign head_ready = adv;

  always_comb begin
    head     = '0;
    head.zl  = head_zl;
    head.neg = head_neg;
    head.mag = head_mag;
    head.ra  = NORM_BITS'(head_la);
    head.rb  = NORM_BITS'(head_lb);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], head_valid};
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    stage_t prv;
    stage_t nxt;

    if (g == 0) begin : g_first
      assign prv = head;
    end else begin : g_link
      assign prv = pipe_r[g-1];
    end

    if (g < S_FIX) begin : g_norm
      // greedy shift by pairs while still below 2^60
      localparam int B = (1 << (NORM_STEPS - 1)) >> g;
      localparam logic [NORM_BITS-1:0] LIM = NORM_BITS'(1) << (NORM_BITS - 2 - 2 * B);
      always_comb begin
        nxt = prv;
        if (prv.ra < LIM) begin
          nxt.ra = prv.ra << (2 * B);
          nxt.ka = prv.ka + K_BITS'(B);
        end
        if (prv.rb < LIM) begin
          nxt.rb = prv.rb << (2 * B);
          nxt.kb = prv.kb + K_BITS'(B);
        end
      end
    end else if (g == S_FIX) begin : g_fix
      // last pair to reach [2^60, 2^62), clear root lanes
      localparam logic [NORM_BITS-1:0] LIM = NORM_BITS'(1) << (NORM_BITS - 2);
      always_comb begin
        nxt       = prv;
        nxt.rema  = '0;
        nxt.roota = '0;
        nxt.remb  = '0;
        nxt.rootb = '0;
        if (prv.ra < LIM) begin
          nxt.ra = prv.ra << 2;
          nxt.ka = prv.ka + 1'b1;
        end
        if (prv.rb < LIM) begin
          nxt.rb = prv.rb << 2;
          nxt.kb = prv.kb + 1'b1;
        end
      end
    end else if (g < S_DEN) begin : g_root
      // one root digit per stage on both lengths
      sqr_t sa, sb;
      always_comb begin
        sa        = sqrt_step(prv.rema, prv.roota, prv.ra[NORM_BITS-1 -: 2]);
        sb        = sqrt_step(prv.remb, prv.rootb, prv.rb[NORM_BITS-1 -: 2]);
        nxt       = prv;
        nxt.rema  = sa.rem;
        nxt.roota = sa.root;
        nxt.remb  = sb.rem;
        nxt.rootb = sb.root;
        nxt.ra    = prv.ra << 2;
        nxt.rb    = prv.rb << 2;
      end
    end else if (g == S_DEN) begin : g_den
      // product of roots and scaled numerator
      logic [K_BITS+1:0] ksum;
      always_comb begin
        ksum    = (K_BITS+2)'(prv.ka) + (K_BITS+2)'(prv.kb) + (K_BITS+2)'(COS_FRAC);
        nxt     = prv;
        nxt.den = NORM_BITS'(prv.roota) * NORM_BITS'(prv.rootb);
        nxt.num = NW'(prv.mag) << ksum;
      end
    end else if (g == S_DINIT) begin : g_dinit
      // quotient too large for the digit range saturates
      logic [HW-1:0] hi;
      always_comb begin
        hi       = prv.num[NW-1:Q_BITS];
        nxt      = prv;
        nxt.sat  = (hi >= HW'(prv.den));
        nxt.drem = hi[DRW-1:0];
        nxt.q    = '0;
      end
    end else if (g < S_QC) begin : g_div
      // restoring divide, one quotient bit per stage
      localparam int J = g - S_DIV0;
      logic [DRW-1:0] t;
      always_comb begin
        t   = {prv.drem[DRW-2:0], prv.num[Q_BITS-1-J]};
        nxt = prv;
        if (t >= DRW'(prv.den)) begin
          nxt.drem = t - DRW'(prv.den);
          nxt.q    = {prv.q[Q_BITS-2:0], 1'b1};
        end else begin
          nxt.drem = t;
          nxt.q    = {prv.q[Q_BITS-2:0], 1'b0};
        end
      end
    end else if (g == S_QC) begin : g_qc
      // clamp cosine magnitude to one
      localparam logic [Q_BITS-1:0] ONE = Q_BITS'(1) << COS_FRAC;
      always_comb begin
        nxt    = prv;
        nxt.qc = (prv.sat || prv.q > ONE) ? QC_BITS'(ONE) : prv.q[QC_BITS-1:0];
      end
    end else if (g == S_SQ) begin : g_sq
      // 2^30 - c^2 for the sine root
      logic [SV_BITS-1:0] sv;
      always_comb begin
        sv        = (SV_BITS'(1) << (2 * COS_FRAC)) - SV_BITS'(prv.qc) * SV_BITS'(prv.qc);
        nxt       = prv;
        nxt.ra    = {sv, (NORM_BITS-SV_BITS)'(0)};
        nxt.rema  = '0;
        nxt.roota = '0;
      end
    end else if (g < S_CINIT) begin : g_sroot
      sqr_t ss;
      always_comb begin
        ss        = sqrt_step(prv.rema, prv.roota, prv.ra[NORM_BITS-1 -: 2]);
        nxt       = prv;
        nxt.rema  = ss.rem;
        nxt.roota = ss.root;
        nxt.ra    = prv.ra << 2;
      end
    end else if (g == S_CINIT) begin : g_cinit
      // obtuse angles start from a quarter turn
      logic [SROOT_BITS-1:0] s;
      always_comb begin
        s   = prv.roota[SROOT_BITS-1:0];
        nxt = prv;
        if (prv.neg && prv.qc != '0) begin
          nxt.cx = XY_BITS'(s);
          nxt.cy = XY_BITS'(prv.qc);
          nxt.cz = Z_BITS'(Z_QUARTER);
        end else begin
          nxt.cx = XY_BITS'(prv.qc);
          nxt.cy = XY_BITS'(s);
          nxt.cz = '0;
        end
      end
    end else if (g < S_ROUND) begin : g_cordic
      // vectoring iteration
      localparam int J = g - S_CORD0;
      logic signed [XY_BITS-1:0] x, y;
      always_comb begin
        x   = prv.cx;
        y   = prv.cy;
        nxt = prv;
        if (y > 0) begin
          nxt.cx = x + (y >>> J);
          nxt.cy = y - (x >>> J);
          nxt.cz = prv.cz + Z_BITS'(ATAN_DEG_Q16[J]);
        end else begin
          nxt.cx = x - (y >>> J);
          nxt.cy = y + (x >>> J);
          nxt.cz = prv.cz - Z_BITS'(ATAN_DEG_Q16[J]);
        end
      end
    end else begin : g_round
      // clamp, round half up, clamp again
      logic signed [Z_BITS-1:0] z;
      logic [ZC_BITS-1:0]       zc;
      logic [ZC_BITS:0]         rnd;
      logic [AW-1:0]            a;
      always_comb begin
        z = prv.cz;
        if (z < 0) begin
          zc = '0;
        end else if (z > Z_BITS'(Z_HALF)) begin
          zc = ZC_BITS'(Z_HALF);
        end else begin
          zc = z[ZC_BITS-1:0];
        end
        rnd     = (ZC_BITS+1)'(zc) + RND;
        a       = AW'(rnd >> (Z_FRAC - ANGLE_FRAC_BITS));
        nxt     = prv;
        nxt.ang = prv.zl ? '0 : ((a > ANG_MAX) ? ANG_MAX : a);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[g] <= nxt;
      end
    end
  end

  assign out_valid       = vld_r[NS-1];
  assign out_angle_deg   = pipe_r[NS-1].ang;
  assign out_zero_length = pipe_r[NS-1].zl;

endmodule

[hw/rtl/vector_angle_degrees.sv]
// ----------------------------------------------------------------------------
// vector_angle_degrees
// Angle between two 3D integer vectors, in degrees with fraction bits.
// ----------------------------------------------------------------------------
// Usage: present both vectors on the in_ ports with in_valid; a beat is taken
// on a clock edge where in_valid is high and in_stall is low. Each beat gives
// exactly one result beat on the out_ ports, taken when out_valid is high and
// out_stall is low; results keep input order.
// Throughput: one beat per cycle while out_stall is low. The classifier forms the dot product and
// squared lengths in the accept cycle and writes a four-entry queue; the
// arithmetic pipeline pulls one entry per cycle through normalize, two
// 31-digit roots, a 17-digit divide, a 16-digit root and 16 cordic steps.
// Stall: out_stall with a result waiting freezes the whole arithmetic pipeline;
// the queue keeps taking beats until its four entries are full, then in_stall rises.
// A zero-length vector gives angle 0 with out_zero_length set.
// Reset: rst_n low clears the queue and all pipeline valid bits.
// ----------------------------------------------------------------------------
module vector_angle_degrees #(
  parameter int COORD_BITS      = vad_pkg::COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_first_x,
  input  logic signed [COORD_BITS-1:0]  in_first_y,
  input  logic signed [COORD_BITS-1:0]  in_first_z,
  input  logic signed [COORD_BITS-1:0]  in_second_x,
  input  logic signed [COORD_BITS-1:0]  in_second_y,
  input  logic signed [COORD_BITS-1:0]  in_second_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [8+ANGLE_FRAC_BITS-1:0]  out_angle_deg,
  output logic                          out_zero_length
);
  import vad_pkg::*;

  localparam int MW = 2 * COORD_BITS;
  localparam int DW = 2 + 3 * MW;

  logic          q_full;
  logic          push_valid, push_zl, push_neg;
  logic [MW-1:0] push_mag, push_la, push_lb;
  logic [DW-1:0] push_data, pop_data;
  logic          pop_valid, pop_ready;

  // classifier
  vad_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_first_z  (in_first_z),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .in_second_z (in_second_z),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_zl     (push_zl),
    .push_neg    (push_neg),
    .push_mag    (push_mag),
    .push_la     (push_la),
    .push_lb     (push_lb)
  );

  assign push_data = {push_zl, push_neg, push_mag, push_la, push_lb};

  // decoupling queue
  vad_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // arithmetic pipeline
  vad_back #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (pop_valid),
    .head_ready      (pop_ready),
    .head_zl         (pop_data[DW-1]),
    .head_neg        (pop_data[DW-2]),
    .head_mag        (pop_data[3*MW-1:2*MW]),
    .head_la         (pop_data[2*MW-1:MW]),
    .head_lb         (pop_data[MW-1:0]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_deg   (out_angle_deg),
    .out_zero_length (out_zero_length)
  );

endmodule

[verif/vector_angle_degrees_chk.sv]
// ----------------------------------------------------------------------------
// vector_angle_degrees_chk
// Watches both channels of the vector angle block, predicts each result beat
// from the accepted input beat and compares angle and zero flag in order.
// ----------------------------------------------------------------------------
module vector_angle_degrees_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [14:0]        out_angle_deg,
  input  logic               out_zero_length,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] angle;
    logic        zero_len;
  } angle_res_t;

  angle_res_t angle_q[$];

  // arctangent steps in degrees, 16 fraction bits
  localparam longint ATAN_STEP [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic angle_res_t predict_angle(longint ax, longint ay, longint az,
                                               longint bx, longint by, longint bz);
    angle_res_t r;
    longint dot, c, s, x, y, z, nx, ny;
    longint unsigned la, lb, ma, mb, den, mag, q, rem, ang;
    int ka, kb, e;
    dot = ax * bx + ay * by + az * bz;
    la = ax * ax + ay * ay + az * az;
    lb = bx * bx + by * by + bz * bz;
    r.angle = '0;
    r.zero_len = 1'b1;
    if (la == 0 || lb == 0) return r;
    // normalize squared lengths to [2^60, 2^62)
    ka = 0;
    while (la < (64'd1 << 60)) begin la <<= 2; ka++; end
    kb = 0;
    while (lb < (64'd1 << 60)) begin lb <<= 2; kb++; end
    ma = int_root(la);
    mb = int_root(lb);
    den = ma * mb;
    mag = dot < 0 ? -dot : dot;
    // cosine magnitude by restoring division
    q = mag / den;
    rem = mag % den;
    e = 15 + ka + kb;
    for (int i = 0; i < e && q <= 65536; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin rem -= den; q |= 1; end
    end
    if (q > 32768) q = 32768;
    c = dot < 0 ? -longint'(q) : longint'(q);
    s = int_root((64'd1 << 30) - q * q);
    // cordic vectoring, pre-rotated for negative cosine
    if (c < 0) begin x = s; y = -c; z = 90 <<< 16; end
    else begin x = c; y = s; z = 0; end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_STEP[i];
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > (180 <<< 16)) z = 180 <<< 16;
    ang = (longint'(z) + (1 << 8)) >> 9;
    if (ang > (180 << 7)) ang = 180 << 7;
    r.angle = ang[14:0];
    r.zero_len = 1'b0;
    return r;
  endfunction

  assign pending = angle_q.size();

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    angle_res_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        angle_q.push_back(predict_angle(in_first_x, in_first_y, in_first_z,
                                        in_second_x, in_second_y, in_second_z));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (angle_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat angle=%0d", out_angle_deg);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = angle_q.pop_front();
          if (exp_r.angle !== out_angle_deg || exp_r.zero_len !== out_zero_length) begin
            if (fail_count < 10)
              $display("mismatch: angle exp %0d got %0d, zero exp %0d got %0d",
                       exp_r.angle, out_angle_deg, exp_r.zero_len, out_zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[verif/vector_angle_degrees_tb.sv]
// ----------------------------------------------------------------------------
// vector_angle_degrees_tb
// Drives directed and random vector pairs with random idling on both sides
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module vector_angle_degrees_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_first_x, in_first_y, in_first_z;
  logic signed [15:0] in_second_x, in_second_y, in_second_z;
  logic out_valid;
  logic out_stall;
  logic [14:0] out_angle_deg;
  logic out_zero_length;
  int fail_count, pending, result_count;
  int idle_cycles;
  bit quiet_tail;
  bit sent_done;

  vector_angle_degrees dut (.*);

  vector_angle_degrees_chk chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // present one beat and hold until taken, valid stays high back to back unless a random idle gap comes first
  task automatic send_pair(logic [15:0] ax, ay, az, bx, by, bz);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_first_x <= ax; in_first_y <= ay; in_first_z <= az;
    in_second_x <= bx; in_second_y <= by; in_second_z <= bz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ax, ay, az, m;
    in_valid = 0;
    in_first_x = 0; in_first_y = 0; in_first_z = 0;
    in_second_x = 0; in_second_y = 0; in_second_z = 0;
    quiet_tail = 0;
    sent_done = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero vectors, parallel, opposite, orthogonal, extremes
    send_pair(0, 0, 0, 1, 2, 3);
    send_pair(5, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 1, 0, 0);
    send_pair(1, 0, 0, -1, 0, 0);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pair(16'h8000, 0, 0, 16'h7fff, 0, 0);
    send_pair(1, 1, 0, 1, 0, 0);
    send_pair(1, 1, 1, -1, -1, 1);
    send_pair(3, 4, 0, 6, 8, 0);
    send_pair(16'h7fff, 1, 0, 16'h7fff, 0, 0);
    send_pair(-1, -1, -1, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'hffff, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'hffff);
    in_valid <= 0;
    // pause until every result is home
    while (pending != 0) @(posedge clk);
    // random pairs, some scaled copies and negations
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - 150) quiet_tail = 1;
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      case ($urandom_range(0, 7))
        0: send_pair(ax, ay, az, ax, ay, az);
        1: send_pair(ax, ay, az, -ax, -ay, -az);
        2: begin
          m = 16'($urandom_range(1, 3));
          send_pair(ax >>> 2, ay >>> 2, az >>> 2, (ax >>> 2) * m, (ay >>> 2) * m,
                    (az >>> 2) * m);
        end
        default: send_pair(ax, ay, az, rand_coord(), rand_coord(), rand_coord());
      endcase
    end
    in_valid <= 0;
    sent_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d directed and %0d random vector pairs, %0d results checked",
             16, RANDOM_BEATS, result_count);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
